@@ rtl/core/tcs_pkg.sv @@
// Shared types and constants for the tick scheduler.
package tcs_pkg;

  localparam int unsigned MaxTasksDef = 16;

  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_READY = 2'd1,
    PH_IO    = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    POL_FCFS    = 3'd0,
    POL_SJF     = 3'd1,
    POL_SJF_P   = 3'd2,
    POL_PRIO    = 3'd3,
    POL_PRIO_P  = 3'd4,
    POL_RR      = 3'd5,
    POL_RSVD6   = 3'd6,
    POL_RSVD7   = 3'd7
  } policy_e;

  typedef enum logic [1:0] {
    REG_POLICY  = 2'd0,
    REG_QUANTUM = 2'd1,
    REG_TASKS   = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_FETCH = 2'd2,
    ST_EXEC  = 2'd3
  } state_e;

  // One task slot as held in the slot memory.
  typedef struct packed {
    logic [15:0] order_key;
    logic [7:0]  io_cnt;
    logic [7:0]  run_cnt;
    logic [7:0]  io_len;
    logic [7:0]  slice;
    logic [6:0]  prio;
    logic [7:0]  remaining;
    logic [7:0]  arrival;
  } task_rec_t;

  localparam int unsigned RecW = $bits(task_rec_t);

  // Result of the per-tick wakeup and arrival update of one slot.
  typedef struct packed {
    task_rec_t   rec;
    phase_e      phase;
    logic        ready;
    logic [15:0] key;
  } upd_res_t;

endpackage

@@ rtl/core/tcs_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module tcs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/core/tcs_upd.sv @@
// Per-slot tick update: i/o wakeup, arrival check and selection key.
module tcs_upd (
  input  tcs_pkg::task_rec_t rec_i,
  input  tcs_pkg::phase_e    phase_i,
  input  logic [15:0]        time_i,
  input  tcs_pkg::policy_e   policy_i,
  output tcs_pkg::upd_res_t  res_o
);

  always_comb begin
    res_o.rec   = rec_i;
    res_o.phase = phase_i;
    if (phase_i == tcs_pkg::PH_IO) begin
      if (rec_i.io_cnt == rec_i.io_len) begin
        res_o.rec.io_cnt    = 8'd0;
        res_o.phase         = tcs_pkg::PH_READY;
        res_o.rec.order_key = time_i;
      end else begin
        res_o.rec.io_cnt = rec_i.io_cnt + 8'd1;
      end
    end
    if (res_o.phase == tcs_pkg::PH_WAIT && {8'd0, rec_i.arrival} == time_i) begin
      res_o.phase         = tcs_pkg::PH_READY;
      res_o.rec.order_key = time_i;
    end
    res_o.ready = (res_o.phase == tcs_pkg::PH_READY);
    unique case (policy_i)
      tcs_pkg::POL_SJF, tcs_pkg::POL_SJF_P:   res_o.key = {8'd0, rec_i.remaining};
      tcs_pkg::POL_PRIO, tcs_pkg::POL_PRIO_P: res_o.key = {9'd0, rec_i.prio};
      default:                                res_o.key = res_o.rec.order_key;
    endcase
  end

endmodule

@@ rtl/core/tick_cpu_scheduler.sv @@
// Top level of the per-tick task scheduler with six selection policies.
// A load beat with a valid slot is written to the slot memory in the idle state. A tick beat
// goes from its accept through a pass over the active slots of the slot memory, a read of the
// chosen slot, and a commit that also fills the output register. The commit waits while that
// register is full. Reset clears phases, time, holder, done count and registers to their defaults.
module tick_cpu_scheduler #(
  parameter int unsigned MAX_TASKS = tcs_pkg::MaxTasksDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  // Command stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata, low to high: slot[3:0], arrive_at[11:4], burst_len[19:12], prio[26:20],
  // run_slice[34:27], io_len[42:35], zero fill[47:43].
  input  logic [47:0] s_axis_tdata_i,
  // tuser: cmd (0 load, 1 tick).
  input  logic        s_axis_tuser_i,
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata, low to high: busy_res[0], run_slot[4:1], finished[5], blocked[6],
  // all_done[7], tick_time[23:8].
  output logic [23:0] m_axis_tdata_o
);

  localparam int unsigned IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned NW = $clog2(MAX_TASKS + 1);

  // Configuration registers.
  tcs_pkg::policy_e policy_q;
  logic [7:0]       quantum_q;
  logic [4:0]       task_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q     <= tcs_pkg::POL_FCFS;
      quantum_q    <= 8'd4;
      task_count_q <= 5'd1;
    end else if (cfg_we_i) begin
      unique case (tcs_pkg::reg_idx_e'(cfg_idx_i))
        tcs_pkg::REG_POLICY:  policy_q     <= tcs_pkg::policy_e'(cfg_data_i[2:0]);
        tcs_pkg::REG_QUANTUM: quantum_q    <= cfg_data_i;
        tcs_pkg::REG_TASKS:   task_count_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Number of slots that take part in a tick.
  logic [NW-1:0] n_slots;
  always_comb begin
    if (32'(task_count_q) >= MAX_TASKS) n_slots = NW'(MAX_TASKS);
    else                                n_slots = NW'(task_count_q);
  end

  tcs_pkg::state_e state_q, state_d;

  tcs_pkg::phase_e phase_q [MAX_TASKS];
  logic [15:0]     time_q;
  logic            holder_valid_q;
  logic [IW-1:0]   holder_slot_q;
  logic [4:0]      done_count_q;

  // Scan pipeline: cnt_q issues reads, proc_q marks the slot whose data is back.
  logic [NW-1:0]   cnt_q;
  logic            proc_q;
  logic [IW-1:0]   proc_idx_q;
  logic            best_valid_q;
  logic [IW-1:0]   best_idx_q;
  logic [15:0]     best_key_q;
  logic            hold_rdy_q;
  logic            sel_valid_q;
  logic [IW-1:0]   sel_idx_q;

  logic            out_valid_q;
  logic [23:0]     out_data_q;

  // Slot memory.
  logic                ram_we;
  logic [IW-1:0]       ram_waddr, ram_raddr;
  tcs_pkg::task_rec_t  ram_wdata, ram_rdata;
  logic [tcs_pkg::RecW-1:0] ram_rbits;

  tcs_ram #(.Width(tcs_pkg::RecW), .Depth(2 ** IW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rbits)
  );
  assign ram_rdata = tcs_pkg::task_rec_t'(ram_rbits);

  tcs_pkg::upd_res_t upd;
  tcs_upd u_upd (
    .rec_i    (ram_rdata),
    .phase_i  (phase_q[proc_idx_q]),
    .time_i   (time_q),
    .policy_i (policy_q),
    .res_o    (upd)
  );

  logic in_acc, is_load, load_ok, scan_done, out_free, preempt;
  logic [IW-1:0] load_idx;
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign is_load   = !s_axis_tuser_i;
  assign load_ok   = (32'(s_axis_tdata_i[3:0]) < MAX_TASKS);
  assign load_idx  = IW'(s_axis_tdata_i[3:0]);
  assign scan_done = (cnt_q == n_slots) && !proc_q;
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign preempt   = (policy_q == tcs_pkg::POL_SJF_P) || (policy_q == tcs_pkg::POL_PRIO_P);

  // Candidate tracking folded with the slot being processed.
  logic          cand_take;
  logic          pick_valid;
  logic [IW-1:0] pick_idx;
  always_comb begin
    cand_take = proc_q && upd.ready && (!best_valid_q || upd.key < best_key_q);
    if (!preempt && holder_valid_q && hold_rdy_q) begin
      pick_valid = 1'b1;
      pick_idx   = holder_slot_q;
    end else begin
      pick_valid = best_valid_q;
      pick_idx   = best_idx_q;
    end
  end

  // Execution of the chosen slot.
  tcs_pkg::task_rec_t exe_rec;
  tcs_pkg::phase_e    exe_phase;
  logic               exe_fin, exe_blk;
  logic [7:0]         exe_lim, exe_rc;
  logic [4:0]         done_next;
  always_comb begin
    exe_rec   = ram_rdata;
    exe_phase = tcs_pkg::PH_READY;
    exe_fin   = 1'b0;
    exe_blk   = 1'b0;
    exe_lim   = (policy_q == tcs_pkg::POL_RR) ? quantum_q : ram_rdata.slice;
    exe_rc    = ram_rdata.run_cnt + 8'd1;
    exe_rec.run_cnt = exe_rc;
    if (ram_rdata.remaining <= 8'd1) begin
      exe_rec.remaining = 8'd0;
      exe_rec.run_cnt   = 8'd0;
      exe_phase         = tcs_pkg::PH_DONE;
      exe_fin           = 1'b1;
    end else begin
      exe_rec.remaining = ram_rdata.remaining - 8'd1;
      if (exe_rc == exe_lim) begin
        exe_rec.run_cnt = 8'd0;
        exe_rec.io_cnt  = 8'd0;
        exe_phase       = tcs_pkg::PH_IO;
        exe_blk         = 1'b1;
      end
    end
    done_next = done_count_q;
    if (sel_valid_q && exe_fin && done_count_q != 5'd31) done_next = done_count_q + 5'd1;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcs_pkg::ST_IDLE:  if (in_acc && !is_load) state_d = tcs_pkg::ST_SCAN;
      tcs_pkg::ST_SCAN:  if (scan_done) state_d = tcs_pkg::ST_FETCH;
      tcs_pkg::ST_FETCH: state_d = tcs_pkg::ST_EXEC;
      tcs_pkg::ST_EXEC:  if (out_free) state_d = tcs_pkg::ST_IDLE;
      default:           state_d = tcs_pkg::ST_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = proc_idx_q;
    ram_wdata = upd.rec;
    ram_raddr = cnt_q[IW-1:0];
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      tcs_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        ram_we    = in_acc && is_load && load_ok;
        ram_waddr = load_idx;
        ram_wdata = '{order_key: 16'd0, io_cnt: 8'd0, run_cnt: 8'd0,
                      io_len: s_axis_tdata_i[42:35], slice: s_axis_tdata_i[34:27],
                      prio: s_axis_tdata_i[26:20], remaining: s_axis_tdata_i[19:12],
                      arrival: s_axis_tdata_i[11:4]};
      end
      tcs_pkg::ST_SCAN: begin
        ram_we = proc_q;
      end
      tcs_pkg::ST_FETCH: begin
        ram_raddr = sel_idx_q;
      end
      tcs_pkg::ST_EXEC: begin
        ram_we    = out_free && sel_valid_q;
        ram_waddr = sel_idx_q;
        ram_wdata = exe_rec;
        ram_raddr = sel_idx_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= tcs_pkg::ST_IDLE;
      for (int i = 0; i < MAX_TASKS; i++) phase_q[i] <= tcs_pkg::PH_WAIT;
      time_q         <= 16'd0;
      holder_valid_q <= 1'b0;
      holder_slot_q  <= '0;
      done_count_q   <= 5'd0;
      cnt_q          <= '0;
      proc_q         <= 1'b0;
      proc_idx_q     <= '0;
      best_valid_q   <= 1'b0;
      best_idx_q     <= '0;
      best_key_q     <= 16'd0;
      hold_rdy_q     <= 1'b0;
      sel_valid_q    <= 1'b0;
      sel_idx_q      <= '0;
      out_valid_q    <= 1'b0;
      out_data_q     <= 24'd0;
    end else begin
      state_q <= state_d;
      // The result beat leaves unless the commit refills the register on the same edge.
      if (m_axis_tready_i && !(state_q == tcs_pkg::ST_EXEC && out_free)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        tcs_pkg::ST_IDLE: begin
          cnt_q        <= '0;
          proc_q       <= 1'b0;
          best_valid_q <= 1'b0;
          hold_rdy_q   <= 1'b0;
          if (in_acc && is_load && load_ok) begin
            // A reload takes back a finished task and drops it as holder.
            if (phase_q[load_idx] == tcs_pkg::PH_DONE && done_count_q != 5'd0) begin
              done_count_q <= done_count_q - 5'd1;
            end
            if (holder_valid_q && holder_slot_q == load_idx) holder_valid_q <= 1'b0;
            phase_q[load_idx] <= tcs_pkg::PH_WAIT;
          end
        end
        tcs_pkg::ST_SCAN: begin
          if (cnt_q != n_slots) begin
            proc_q     <= 1'b1;
            proc_idx_q <= cnt_q[IW-1:0];
            cnt_q      <= cnt_q + NW'(1);
          end else begin
            proc_q <= 1'b0;
          end
          if (proc_q) begin
            phase_q[proc_idx_q] <= upd.phase;
            if (proc_idx_q == holder_slot_q) hold_rdy_q <= upd.ready;
          end
          if (cand_take) begin
            best_valid_q <= 1'b1;
            best_idx_q   <= proc_idx_q;
            best_key_q   <= upd.key;
          end
          if (scan_done) begin
            sel_valid_q <= pick_valid;
            sel_idx_q   <= pick_idx;
          end
        end
        tcs_pkg::ST_FETCH: ;
        tcs_pkg::ST_EXEC: begin
          if (out_free) begin
            if (sel_valid_q) begin
              phase_q[sel_idx_q] <= exe_phase;
              holder_valid_q     <= !exe_fin && !exe_blk;
              holder_slot_q      <= sel_idx_q;
            end else begin
              holder_valid_q <= 1'b0;
            end
            done_count_q <= done_next;
            out_valid_q  <= 1'b1;
            out_data_q   <= {time_q,
                             done_next >= task_count_q,
                             sel_valid_q && exe_blk,
                             sel_valid_q && exe_fin,
                             sel_valid_q ? 4'(sel_idx_q) : 4'd0,
                             sel_valid_q};
            time_q       <= time_q + 16'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
